[rtl/core/vaun_pkg.sv]
`default_nettype none

package vaun_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int LANES         = 4;
   localparam int ROOT_BITS     = 32;
   localparam int QUO_BITS      = 33;

   localparam logic [2:0] ACT_ADD  = 3'd0;
   localparam logic [2:0] ACT_SUB  = 3'd1;
   localparam logic [2:0] ACT_ADDS = 3'd2;
   localparam logic [2:0] ACT_SUBS = 3'd3;
   localparam logic [2:0] ACT_MULS = 3'd4;
   localparam logic [2:0] ACT_DIVZ = 3'd5;
   localparam logic [2:0] ACT_DIVK = 3'd6;
   localparam logic [2:0] ACT_NORM = 3'd7;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] a_w;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] b_w;
      logic signed [31:0] scalar_in;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic signed [31:0] r_w;
      logic               zero_guard;
      logic               saturated;
   } rsp_word_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
      logic [63:0] rad;
   } sqrt_state_type;

   typedef struct packed {
      logic [32:0] rem;
      logic [32:0] low;
      logic [32:0] quo;
   } div_lane_type;

   typedef struct packed {
      div_lane_type [LANES-1:0] lane;
      logic [32:0]              dsr;
   } div_state_type;

   typedef struct packed {
      logic                       use_early;
      logic                       is_mul;
      logic                       is_norm;
      logic                       hi;
      logic                       guard;
      logic                       sat;
      logic [LANES-1:0]           neg;
      logic [LANES-1:0]           ovf;
      logic [LANES-1:0][31:0]     early_r;
      logic [LANES-1:0][31:0]     mag_a;
      logic [31:0]                mag_s;
   } side_type;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      logic [31:0] n;
      n = 32'd0 - v;
      return v[31] ? n : v;
   endfunction

   // {clamped, value} for a 33-bit two's complement sum
   function automatic logic [32:0] clamp_sum(input logic [32:0] v);
      if (v[32] != v[31]) begin
         return v[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
      end
      return {1'b0, v[31:0]};
   endfunction

   // {clamped, value}: apply sign to a magnitude; big marks a magnitude past 33 bits
   function automatic logic [32:0] clamp_mag(input logic neg, input logic big,
                                             input logic [32:0] mag);
      logic [32:0] twos;
      twos = 33'd0 - mag;
      if (neg) begin
         if (big || mag > 33'h0_8000_0000) return {1'b1, 32'h8000_0000};
         return {1'b0, twos[31:0]};
      end
      if (big || mag > 33'h0_7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
      return {1'b0, mag[31:0]};
   endfunction

endpackage

`default_nettype wire

[rtl/core/vaun_sqrt_cell.sv]
`default_nettype none

module vaun_sqrt_cell import vaun_pkg::*; (
   input  logic           clock,
   input  sqrt_state_type up_state,
   output sqrt_state_type down_state
);

   sqrt_state_type state_ff, state_in;
   logic [35:0]    rem_sh, trial, diff;

   // one root bit: bring down two radicand bits, try 4r+1
   always_comb begin
      rem_sh       = {up_state.rem, up_state.rad[63:62]};
      trial        = {2'b00, up_state.root, 2'b01};
      diff         = rem_sh - trial;
      state_in.rad = {up_state.rad[61:0], 2'b00};
      if (rem_sh >= trial) begin
         state_in.rem  = diff[33:0];
         state_in.root = {up_state.root[30:0], 1'b1};
      end else begin
         state_in.rem  = rem_sh[33:0];
         state_in.root = {up_state.root[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign down_state = state_ff;

endmodule

`default_nettype wire

[rtl/core/vaun_div_cell.sv]
`default_nettype none

module vaun_div_cell import vaun_pkg::*; (
   input  logic          clock,
   input  div_state_type up_state,
   output div_state_type down_state
);

   div_state_type state_ff, state_in;
   logic [33:0]   rem_sh [LANES];
   logic [33:0]   diff   [LANES];

   // one quotient bit in each lane, shared divisor
   always_comb begin
      state_in.dsr = up_state.dsr;
      for (int i = 0; i < LANES; i++) begin
         rem_sh[i] = {up_state.lane[i].rem, up_state.lane[i].low[32]};
         diff[i]   = rem_sh[i] - {1'b0, up_state.dsr};
         state_in.lane[i].low = {up_state.lane[i].low[31:0], 1'b0};
         if (rem_sh[i] >= {1'b0, up_state.dsr}) begin
            state_in.lane[i].rem = diff[i][32:0];
            state_in.lane[i].quo = {up_state.lane[i].quo[31:0], 1'b1};
         end else begin
            state_in.lane[i].rem = rem_sh[i][32:0];
            state_in.lane[i].quo = {up_state.lane[i].quo[31:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign down_state = state_ff;

endmodule

`default_nettype wire

[rtl/core/vec4_arith_normalize_unit.sv]
`default_nettype none

// Four-lane Q(32-FRAC_BITS).FRAC_BITS vector unit: add, subtract, scalar add and
// subtract, scalar multiply, scalar divide (zeroing or keeping a on a zero
// divisor) and normalize of vector a.
// Request: drive req_word and raise start; the word is taken at any rising
// edge with start high and busy low. busy is high only while reset is held,
// so one word can be taken in every cycle.
// Response: rsp_word is valid for exactly one cycle, marked by rsp_strobe.
// The receiver cannot stall it and must take it in that cycle.
// Depth: 70 register stages, the same for every action. The depth is set by
// the 32-cell square root chain and the 33-cell quotient chain that every
// word passes.
// Throughput: one word per cycle; results return in request order.
// Reset (synchronous, active high) drops every word in flight; no strobe
// comes for them. There is no other state.
// zero_guard marks a zero divisor or a zero-length vector; saturated marks
// any component clamped to the 32-bit range.
module vec4_arith_normalize_unit import vaun_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_word_type req_word,
   output logic         busy,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   localparam int NUM_W     = 32 + FRAC_BITS;
   localparam int HEAD_W    = NUM_W - QUO_BITS;
   localparam int PIPE_REGS = 5 + ROOT_BITS + QUO_BITS;

   assign busy = reset;

   // ---------------------------------------------------------------- input
   req_word_type req_ff;
   logic         v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_word;
   end

   // ------------------------------------- operand prep, multiply, add/sub
   logic [LANES-1:0][31:0] a_raw, b_raw;
   logic [LANES-1:0][63:0] prod_in, prod_ff;
   logic [31:0]            mag_s, mul_op [LANES];
   logic [32:0]            sum_v [LANES];
   logic [32:0]            clamp_v [LANES];
   logic                   s_zero, s_neg, a_zero, sat_any;
   side_type               side_b_in, side_b_ff;
   logic                   vb_ff;

   assign a_raw = {req_ff.a_w, req_ff.a_z, req_ff.a_y, req_ff.a_x};
   assign b_raw = {req_ff.b_w, req_ff.b_z, req_ff.b_y, req_ff.b_x};

   always_comb begin
      s_neg   = req_ff.scalar_in[31];
      s_zero  = (req_ff.scalar_in == 32'sd0);
      a_zero  = (a_raw == '0);
      mag_s   = mag32(req_ff.scalar_in);
      sat_any = 1'b0;

      side_b_in         = '0;
      side_b_in.is_mul  = (req_ff.action == ACT_MULS);
      side_b_in.is_norm = (req_ff.action == ACT_NORM);
      side_b_in.mag_s   = mag_s;

      for (int i = 0; i < LANES; i++) begin
         side_b_in.mag_a[i] = mag32(a_raw[i]);
         // sign of the true product or quotient; normalize keeps a's sign
         side_b_in.neg[i]   = a_raw[i][31] ^ (s_neg && !side_b_in.is_norm);
         // normalize squares a; every other action multiplies by the scalar
         mul_op[i]  = side_b_in.is_norm ? side_b_in.mag_a[i] : mag_s;
         prod_in[i] = {32'd0, side_b_in.mag_a[i]} * {32'd0, mul_op[i]};

         case (req_ff.action)
            ACT_ADD:  sum_v[i] = {a_raw[i][31], a_raw[i]} + {b_raw[i][31], b_raw[i]};
            ACT_SUB:  sum_v[i] = {a_raw[i][31], a_raw[i]} - {b_raw[i][31], b_raw[i]};
            ACT_ADDS: sum_v[i] = {a_raw[i][31], a_raw[i]} + {s_neg, req_ff.scalar_in};
            ACT_SUBS: sum_v[i] = {a_raw[i][31], a_raw[i]} - {s_neg, req_ff.scalar_in};
            default:  sum_v[i] = '0;
         endcase
         clamp_v[i] = clamp_sum(sum_v[i]);
         sat_any    = sat_any | clamp_v[i][32];
      end

      // resolve add/sub and the guarded cases here; scalar multiply after the product register
      case (req_ff.action)
         ACT_ADD, ACT_SUB, ACT_ADDS, ACT_SUBS: begin
            side_b_in.use_early = 1'b1;
            side_b_in.sat       = sat_any;
            for (int i = 0; i < LANES; i++) begin
               side_b_in.early_r[i] = clamp_v[i][31:0];
            end
         end
         ACT_DIVZ: begin
            if (s_zero) begin
               side_b_in.use_early = 1'b1;
               side_b_in.guard     = 1'b1;
            end
         end
         ACT_DIVK: begin
            if (s_zero) begin
               side_b_in.use_early = 1'b1;
               side_b_in.guard     = 1'b1;
               side_b_in.early_r   = a_raw;
            end
         end
         ACT_NORM: begin
            if (a_zero) begin
               side_b_in.use_early = 1'b1;
               side_b_in.guard     = 1'b1;
            end
         end
         default: begin
            side_b_in.use_early = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      side_b_ff <= side_b_in;
   end

   // -------------------------------- sum of squares, scalar product clamp
   logic [64:0] sq_sum;
   logic [63:0] mul_sh [LANES];
   logic [32:0] mul_cl [LANES];
   logic        mul_sat;
   side_type    side_c_in, side_c_ff;
   logic [63:0] rad_c_ff;
   logic        vc_ff;

   assign sq_sum = {1'b0, prod_ff[0]} + {1'b0, prod_ff[1]}
                 + {1'b0, prod_ff[2]} + {1'b0, prod_ff[3]};

   always_comb begin
      side_c_in    = side_b_ff;
      side_c_in.hi = sq_sum[64];
      mul_sat      = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         mul_sh[i] = prod_ff[i] >> FRAC_BITS;
         mul_cl[i] = clamp_mag(side_b_ff.neg[i], |mul_sh[i][63:33], mul_sh[i][32:0]);
         mul_sat   = mul_sat | mul_cl[i][32];
      end
      if (side_b_ff.is_mul) begin
         side_c_in.use_early = 1'b1;
         side_c_in.sat       = mul_sat;
         for (int i = 0; i < LANES; i++) begin
            side_c_in.early_r[i] = mul_cl[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      side_c_ff <= side_c_in;
      rad_c_ff  <= sq_sum[63:0];
   end

   // ------------------------------------------------ square root chain
   sqrt_state_type         sq_chain [ROOT_BITS+1];
   side_type               side_q_ff [ROOT_BITS];
   logic [ROOT_BITS-1:0]   vq_ff;

   assign sq_chain[0] = {34'd0, 32'd0, rad_c_ff};

   for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
      vaun_sqrt_cell u_cell (
         .clock      (clock),
         .up_state   (sq_chain[g]),
         .down_state (sq_chain[g+1])
      );
   end

   // advance the side data in step with the root cells
   always_ff @(posedge clock) begin
      side_q_ff[0] <= side_c_ff;
      for (int k = 1; k < ROOT_BITS; k++) begin
         side_q_ff[k] <= side_q_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vq_ff <= '0;
      end else begin
         vq_ff <= {vq_ff[ROOT_BITS-2:0], vc_ff};
      end
   end

   // --------------------------------------------- divider setup
   side_type       sd, side_d_in, side_d_ff;
   div_state_type  div_d_in, div_d_ff;
   logic [32:0]    len, dsr;
   logic [NUM_W-1:0] num [LANES];
   logic [32:0]    head [LANES];
   logic           vd_ff;

   assign sd = side_q_ff[ROOT_BITS-1];

   always_comb begin
      // a sum of 2^64 only comes from four most-negative components
      len          = sd.hi ? {1'b1, 32'd0} : {1'b0, sq_chain[ROOT_BITS].root};
      dsr          = sd.is_norm ? len : {1'b0, sd.mag_s};
      side_d_in    = sd;
      div_d_in.dsr = dsr;
      for (int i = 0; i < LANES; i++) begin
         num[i]  = {sd.mag_a[i], {FRAC_BITS{1'b0}}};
         head[i] = 33'(num[i][NUM_W-1 -: HEAD_W]);
         // quotient of 2^33 or more: flag it, the chain result is dropped
         side_d_in.ovf[i]      = (head[i] >= dsr);
         div_d_in.lane[i].rem  = head[i];
         div_d_in.lane[i].low  = num[i][QUO_BITS-1:0];
         div_d_in.lane[i].quo  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else begin
         vd_ff <= vq_ff[ROOT_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      side_d_ff <= side_d_in;
      div_d_ff  <= div_d_in;
   end

   // ------------------------------------------------- quotient chain
   div_state_type        dv_chain [QUO_BITS+1];
   side_type             side_e_ff [QUO_BITS];
   logic [QUO_BITS-1:0]  ve_ff;

   assign dv_chain[0] = div_d_ff;

   for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
      vaun_div_cell u_cell (
         .clock      (clock),
         .up_state   (dv_chain[g]),
         .down_state (dv_chain[g+1])
      );
   end

   always_ff @(posedge clock) begin
      side_e_ff[0] <= side_d_ff;
      for (int k = 1; k < QUO_BITS; k++) begin
         side_e_ff[k] <= side_e_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= '0;
      end else begin
         ve_ff <= {ve_ff[QUO_BITS-2:0], vd_ff};
      end
   end

   // ------------------------------------------------- output select
   side_type               sf;
   logic [LANES-1:0][31:0] r_vec;
   logic [32:0]            fin_cl [LANES];
   logic                   fin_sat;
   rsp_word_type           rsp_word_in, rsp_word_ff;
   logic                   rsp_strobe_ff;

   assign sf = side_e_ff[QUO_BITS-1];

   always_comb begin
      fin_sat = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         fin_cl[i] = clamp_mag(sf.neg[i], sf.ovf[i], dv_chain[QUO_BITS].lane[i].quo);
         fin_sat   = fin_sat | fin_cl[i][32];
      end
      if (sf.use_early) begin
         r_vec                  = sf.early_r;
         rsp_word_in.zero_guard = sf.guard;
         rsp_word_in.saturated  = sf.sat;
      end else begin
         for (int i = 0; i < LANES; i++) begin
            r_vec[i] = fin_cl[i][31:0];
         end
         rsp_word_in.zero_guard = 1'b0;
         rsp_word_in.saturated  = fin_sat;
      end
      rsp_word_in.r_x = r_vec[0];
      rsp_word_in.r_y = r_vec[1];
      rsp_word_in.r_z = r_vec[2];
      rsp_word_in.r_w = r_vec[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ve_ff[QUO_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // ------------------------------------------------- assertions
   // every result word traces back to a word taken a fixed time earlier
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_REGS))
      else $error("result word without a matching request word");

   // a guarded result is never also a clamped one
   a_guard_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_word.zero_guard && rsp_word.saturated))
      else $error("zero_guard and saturated both set");

   // a normalized component never leaves -1.0..+1.0, so it never clamps
   a_norm_no_sat: assert property (@(posedge clock) disable iff (reset)
      (ve_ff[QUO_BITS-1] && sf.is_norm && !sf.use_early) |=> !rsp_word.saturated)
      else $error("normalize result clamped");

endmodule

`default_nettype wire

[bench/vaun_checker.sv]
`default_nettype none

module vaun_checker import vaun_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_word_type req_word,
   input  logic         rsp_strobe,
   input  rsp_word_type rsp_word,
   output int           fail_count,
   output int           expect_depth
);

   localparam int FB = FRAC_BITS_DEF;

   rsp_word_type pending_rsp[$];
   logic sat_seen;
   int   fail_total = 0;

   function automatic logic signed [31:0] clamp_wide(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         sat_seen = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -66'sd2147483648) begin
         sat_seen = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] signed_mag(input logic neg, input logic [95:0] m);
      logic signed [65:0] v;
      if (m > 96'h1_0000_0000) m = 96'h1_0000_0000;
      v = neg ? -$signed({1'b0, m[64:0]}) : $signed({1'b0, m[64:0]});
      return clamp_wide(v);
   endfunction

   function automatic logic [63:0] abs_of(input logic signed [31:0] v);
      return v < 0 ? 64'(-66'(v)) : 64'(v);
   endfunction

   function automatic logic [63:0] root_floor(input logic [65:0] s);
      logic [63:0] r;
      logic [63:0] c;
      r = 0;
      for (int b = 32; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({66'd0, c} * c <= {66'd0, s}) r = c;
      end
      return r;
   endfunction

   function automatic rsp_word_type vector_result(input req_word_type w);
      rsp_word_type o;
      logic signed [31:0] av[4], bv[4], r[4];
      logic signed [31:0] s;
      logic [65:0] sum;
      logic [63:0] len;
      logic neg;
      av = '{w.a_x, w.a_y, w.a_z, w.a_w};
      bv = '{w.b_x, w.b_y, w.b_z, w.b_w};
      s = w.scalar_in;
      sat_seen = 1'b0;
      o = '0;
      r = '{0, 0, 0, 0};
      case (w.action)
         ACT_ADD: for (int i = 0; i < 4; i++) r[i] = clamp_wide(66'(av[i]) + 66'(bv[i]));
         ACT_SUB: for (int i = 0; i < 4; i++) r[i] = clamp_wide(66'(av[i]) - 66'(bv[i]));
         ACT_ADDS: for (int i = 0; i < 4; i++) r[i] = clamp_wide(66'(av[i]) + 66'(s));
         ACT_SUBS: for (int i = 0; i < 4; i++) r[i] = clamp_wide(66'(av[i]) - 66'(s));
         ACT_MULS: for (int i = 0; i < 4; i++) begin
            neg = (av[i] < 0) != (s < 0);
            r[i] = signed_mag(neg, ({32'd0, abs_of(av[i])} * abs_of(s)) >> FB);
         end
         ACT_DIVZ, ACT_DIVK: begin
            if (s == 0) begin
               o.zero_guard = 1'b1;
               if (w.action == ACT_DIVK) r = av;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  neg = (av[i] < 0) != (s < 0);
                  r[i] = signed_mag(neg, ({32'd0, abs_of(av[i])} << FB) / abs_of(s));
               end
            end
         end
         default: begin
            sum = 0;
            for (int i = 0; i < 4; i++) sum += 66'(abs_of(av[i])) * abs_of(av[i]);
            if (sum == 0) begin
               o.zero_guard = 1'b1;
            end else begin
               // a 65-bit sum takes the length 2^32, as the datapath does
               len = sum[65:64] != 0 ? 64'h1_0000_0000 : root_floor(sum);
               for (int i = 0; i < 4; i++)
                  r[i] = signed_mag(av[i] < 0, ({32'd0, abs_of(av[i])} << FB) / len);
            end
         end
      endcase
      o.r_x = r[0];
      o.r_y = r[1];
      o.r_z = r[2];
      o.r_w = r[3];
      o.saturated = sat_seen;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
      fail_total++;
   endtask

   assign fail_count   = fail_total;
   assign expect_depth = pending_rsp.size();

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected word", rsp_word.r_x, 32'd0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_word.r_x !== want.r_x) report_mismatch("r_x", rsp_word.r_x, want.r_x);
            if (rsp_word.r_y !== want.r_y) report_mismatch("r_y", rsp_word.r_y, want.r_y);
            if (rsp_word.r_z !== want.r_z) report_mismatch("r_z", rsp_word.r_z, want.r_z);
            if (rsp_word.r_w !== want.r_w) report_mismatch("r_w", rsp_word.r_w, want.r_w);
            if (rsp_word.zero_guard !== want.zero_guard)
               report_mismatch("zero_guard", 32'(rsp_word.zero_guard),
                               32'(want.zero_guard));
            if (rsp_word.saturated !== want.saturated)
               report_mismatch("saturated", 32'(rsp_word.saturated),
                               32'(want.saturated));
         end
      end
      if (!reset && start && !busy) pending_rsp.push_back(vector_result(req_word));
   end

endmodule

`default_nettype wire

[bench/tb_vec4_arith_normalize_unit.sv]
`default_nettype none

module tb_vec4_arith_normalize_unit;
   import vaun_pkg::*;

   localparam int LATENCY   = 70;
   localparam int STALL_MAX = 2000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   req_word_type req_word = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   int           fail_count;
   int           expect_depth;
   int           idle_cycles = 0;

   vec4_arith_normalize_unit dut (
      .clock(clock), .reset(reset), .start(start), .req_word(req_word),
      .busy(busy), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   vaun_checker checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .fail_count(fail_count), .expect_depth(expect_depth)
   );

   always #5 clock = ~clock;

   // Watchdog: count cycles with no word taken in either direction.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_MAX) begin
            $display("tb_vec4_arith_normalize_unit NOT OK");
            $finish;
         end
      end
   end

   // Pick a component value, favoring edges of the range and small numbers.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'd0;
         3: return 32'(int'($urandom_range(0, 8)) - 4);
         4: return 32'(int'($urandom_range(0, 262144)) - 131072);
         5: return 32'h0001_0000;
         default: return $urandom();
      endcase
   endfunction

   // Hold the word on the ports until it is taken; idle first when asked.
   task automatic send_word(input req_word_type w, input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_word <= w;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_random(input int count, input int idle_pct);
      req_word_type w;
      for (int n = 0; n < count; n++) begin
         w.action    = 3'($urandom_range(0, 7));
         w.a_x       = pick_value();
         w.a_y       = pick_value();
         w.a_z       = pick_value();
         w.a_w       = pick_value();
         w.b_x       = pick_value();
         w.b_y       = pick_value();
         w.b_z       = pick_value();
         w.b_w       = pick_value();
         w.scalar_in = $urandom_range(0, 5) == 0 ? 32'd0 : pick_value();
         send_word(w, idle_pct);
      end
   endtask

   task automatic send_directed();
      req_word_type w;
      logic [2:0] act;
      // Every action on extreme vectors, then on a mixed vector.
      for (int k = 0; k < 8; k++) begin
         act = 3'(k);
         w = '{act, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
         send_word(w, 0);
         w = '{act, 32'h0003_0000, 32'hFFFC_0000, 32'h0000_0001, 32'hFFFF_FFFF,
               32'h0001_8000, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'h0002_0000};
         send_word(w, 0);
      end
      // Zero divisor, both division flavors.
      w = '{ACT_DIVZ, 32'h1234_5678, 32'h8765_4321, 32'd1, 32'h8000_0000,
            32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
      send_word(w, 0);
      w.action = ACT_DIVK;
      send_word(w, 0);
      // Zero-length vector, tiny vector, all-ones pattern, and its scalar multiply by the maximum.
      w = '0;
      w.action = ACT_NORM;
      send_word(w, 0);
      w.a_w = 32'd1;
      send_word(w, 0);
      w = '1;
      send_word(w, 0);
      w.action = ACT_MULS;
      w.scalar_in = 32'h7FFF_FFFF;
      send_word(w, 0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_directed();
      send_random(380, 13);
      send_random(380, 58);
      send_random(370, 0);
      start <= 1'b0;
      while (expect_depth != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_vec4_arith_normalize_unit OK");
      end else begin
         $display("tb_vec4_arith_normalize_unit NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
